@@ rtl/wpm_pkg.sv @@
// Shared types and constants of the wildcard pattern matcher.
package wpm_pkg;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TEXT  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Pattern bytes with a wildcard meaning.
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    // Data handed from one cell to its right neighbor as the sweep moves on.
    typedef struct packed {
        logic tok;       // sweep front is here
        logic old_bit;   // row bit before this byte (initial row on a first byte)
        logic new_bit;   // row bit after this byte
        logic init_bit;  // initial-row bit (star prefix chain)
        logic res;       // result picked up at the pattern length so far
    } link_t;

    // Sweep controls broadcast to every cell.
    typedef struct packed {
        logic       query;
        logic       first;
        logic [7:0] text_byte;
    } bcast_t;

    // Pattern byte load broadcast to every cell.
    typedef struct packed {
        logic       en;
        logic [5:0] position;
        logic [7:0] value;
    } load_t;

endpackage

@@ rtl/wpm_if.sv @@
// Valid/ready channel interfaces of the wildcard pattern matcher.
interface wpm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [5:0] position;
    logic [7:0] byte_value;
    logic       first_of_text;
    logic       last_of_text;

    modport source (output valid, op, position, byte_value, first_of_text, last_of_text,
                    input ready);
    modport sink (input valid, op, position, byte_value, first_of_text, last_of_text,
                  output ready);
endinterface

interface wpm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, matched, input ready);
    modport sink (input valid, matched, output ready);
endinterface

interface wpm_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ rtl/wpm_cell.sv @@
// One pattern position of the matcher: pattern byte, row bit and sweep stage.
module wpm_cell #(
    parameter int INDEX = 1,
    parameter int CW    = 7
) (
    input  logic           clk,
    input  logic           rst_n,
    input  wpm_pkg::link_t left,
    output wpm_pkg::link_t right,
    input  wpm_pkg::bcast_t bc,
    input  wpm_pkg::load_t ld,
    input  logic [CW-1:0]  used_len
);

    logic       tok_reg;
    logic       old_reg;
    logic       new_reg;
    logic       init_reg;
    logic       res_reg;
    logic       row_reg;
    logic [7:0] byte_reg;

    logic is_star;
    logic hit;
    logic init_bit;
    logic old_bit;
    logic new_bit;
    logic res_bit;
    logic load_hit;

    // Match rule for this position and the star prefix chain.
    always_comb
    begin
        is_star  = (byte_reg == wpm_pkg::STAR_BYTE);
        hit      = (byte_reg == wpm_pkg::ANY_BYTE) || (byte_reg == bc.text_byte);
        init_bit = left.init_bit & is_star;
        old_bit  = bc.first ? init_bit : row_reg;
        new_bit  = is_star ? (old_bit | left.new_bit) : (hit & left.old_bit);
        if (used_len == CW'(INDEX))
        begin
            res_bit = bc.query ? init_bit : new_bit;
        end
        else
        begin
            res_bit = left.res;
        end
        load_hit = ld.en && ({{(CW-6){1'b0}}, ld.position} == CW'(INDEX - 1));
    end

    // Sweep front and row bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
            row_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= left.tok;
            if (left.tok && !bc.query)
            begin
                row_reg <= new_bit;
            end
        end
    end

    // Data handed to the right neighbor, and the pattern byte.
    always_ff @(posedge clk)
    begin
        if (left.tok)
        begin
            old_reg  <= old_bit;
            new_reg  <= new_bit;
            init_reg <= init_bit;
            res_reg  <= res_bit;
        end
        if (load_hit)
        begin
            byte_reg <= ld.value;
        end
    end

    assign right.tok      = tok_reg;
    assign right.old_bit  = old_reg;
    assign right.new_bit  = new_reg;
    assign right.init_bit = init_reg;
    assign right.res      = res_reg;

endmodule

@@ rtl/wildcard_pattern_match.sv @@
// Top level of the wildcard pattern matcher: control, result register and cell row.
//
// Matches a streamed text against a stored pattern in which '?' stands for any
// one byte and '*' for any run of bytes. A text byte or an empty-text query runs
// as a sweep front down the row of MAX_PATTERN cells, one cell per cycle, and the
// block takes no new request until the front has left the last cell. The result
// register lets the next request start while a result waits to be taken.
// The pattern length is written over the configuration channel; the user must
// write it only while the block is idle, and the block itself does not enforce
// this. Lengths above MAX_PATTERN act as MAX_PATTERN.
module wildcard_pattern_match #(
    parameter int MAX_PATTERN = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    wpm_in_if.sink    in_ch,
    wpm_out_if.source out_ch,
    wpm_cfg_if.sink   cfg_ch
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int CW = (LW > 7) ? LW : 7;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [6:0]       pattern_length_reg;
    logic             tok_reg;
    wpm_pkg::bcast_t  bc_reg;
    logic             need_reg;
    logic             out_valid_reg, out_valid_next;
    logic             matched_reg, matched_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_reg, pend_next;

    logic             in_ready;
    logic             in_acc;
    logic             start;
    logic [CW-1:0]    length_ext;
    logic [CW-1:0]    used_len;
    wpm_pkg::load_t   ld;
    wpm_pkg::link_t   link [0:MAX_PATTERN];
    logic             done;

    // Request handshake and decode.
    assign in_ready     = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign in_ch.ready  = in_ready;
    assign in_acc       = in_ch.valid && in_ready;
    assign start        = in_acc && ((in_ch.op == wpm_pkg::OP_TEXT) ||
                                     (in_ch.op == wpm_pkg::OP_QUERY));
    assign cfg_ch.ready = 1'b1;

    // Pattern length clamped to the row size.
    assign length_ext = CW'(pattern_length_reg);
    assign used_len   = (length_ext > CW'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : length_ext;

    // Pattern byte load goes straight to the addressed cell.
    assign ld.en       = in_acc && (in_ch.op == wpm_pkg::OP_LOAD);
    assign ld.position = in_ch.position;
    assign ld.value    = in_ch.byte_value;

    // Column zero of the row feeds the first cell.
    assign link[0].tok      = tok_reg;
    assign link[0].old_bit  = bc_reg.first;
    assign link[0].new_bit  = 1'b0;
    assign link[0].init_bit = 1'b1;
    assign link[0].res      = bc_reg.query && (used_len == '0);

    // Row of cells, one per pattern position.
    for (genvar g = 1; g <= MAX_PATTERN; g++)
    begin : g_cell
        wpm_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .left     (link[g-1]),
            .right    (link[g]),
            .bc       (bc_reg),
            .ld       (ld),
            .used_len (used_len)
        );
    end

    assign done = link[MAX_PATTERN].tok;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register with one pending slot behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ch.ready;
        matched_next    = matched_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (!out_valid_reg || out_ch.ready)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                matched_next    = pend_reg;
                pend_valid_next = 1'b0;
            end
            else if (done && need_reg)
            begin
                out_valid_next = 1'b1;
                matched_next   = link[MAX_PATTERN].res;
            end
        end
        else if (done && need_reg)
        begin
            pend_valid_next = 1'b1;
            pend_next       = link[MAX_PATTERN].res;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            pattern_length_reg <= '0;
            tok_reg            <= 1'b0;
            out_valid_reg      <= 1'b0;
            pend_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tok_reg        <= start;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_ch.valid)
            begin
                pattern_length_reg <= cfg_ch.data;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        pend_reg    <= pend_next;
        if (start)
        begin
            bc_reg.query     <= (in_ch.op == wpm_pkg::OP_QUERY);
            bc_reg.first     <= in_ch.first_of_text;
            bc_reg.text_byte <= in_ch.byte_value;
            need_reg         <= (in_ch.op == wpm_pkg::OP_QUERY) || in_ch.last_of_text;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.matched = matched_reg;

    // No request is taken while a sweep runs.
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> !in_ch.ready)
        else $error("request accepted during a sweep");

    // A text or query request launches the sweep front in the next cycle.
    a_sweep_launch: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (tok_reg && (state_reg == ST_SWEEP)))
        else $error("sweep not launched");

    // The sweep front leaves the row only while sweeping.
    a_done_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_SWEEP))
        else $error("sweep front outside a sweep");

    // A pending result exists only behind a held result.
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending result without held result");

endmodule

@@ tb/wpm_match_check.sv @@
`timescale 1ns / 100ps
// Checker that predicts the matcher's results from observed requests and compares them.
module wpm_match_check #(
    parameter int PAT_DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    wpm_in_if    in_mon,
    wpm_out_if   out_mon,
    wpm_cfg_if   cfg_mon,
    output int   failures,
    output int   pending_results
);

    // Predicted state: pattern bytes, match row over pattern prefixes, length register.
    logic [7:0]         pat_mem [PAT_DEPTH];
    logic [PAT_DEPTH:0] row_bits;
    logic [6:0]         len_reg;
    logic               expected_matches [$];

    // Lengths above the store depth act as the full depth.
    function automatic int used_len();
        return (len_reg > PAT_DEPTH) ? PAT_DEPTH : int'(len_reg);
    endfunction

    // Row for the empty text: bit j is set while the first j pattern bytes are all stars.
    function automatic logic [PAT_DEPTH:0] empty_text_row();
        logic [PAT_DEPTH:0] r;
        int j;
        r[0] = 1'b1;
        for (j = 1; j <= PAT_DEPTH; j++)
        begin
            r[j] = r[j - 1] && (pat_mem[j - 1] == wpm_pkg::STAR_BYTE);
        end
        return r;
    endfunction

    // Advances the row by one text byte against the pattern as it stands now.
    function automatic logic [PAT_DEPTH:0] advance_row(input logic [PAT_DEPTH:0] prev,
                                                       input logic [7:0] c);
        logic [PAT_DEPTH:0] nxt;
        logic [7:0]         q;
        int                 j;
        nxt[0] = 1'b0;
        for (j = 1; j <= PAT_DEPTH; j++)
        begin
            q = pat_mem[j - 1];
            if (q == wpm_pkg::STAR_BYTE)
            begin
                nxt[j] = prev[j] | nxt[j - 1];
            end
            else if (q == wpm_pkg::ANY_BYTE || q == c)
            begin
                nxt[j] = prev[j - 1];
            end
            else
            begin
                nxt[j] = 1'b0;
            end
        end
        return nxt;
    endfunction

    // Results are checked before new requests are predicted, so the order of the queue holds.
    always @(posedge clk or negedge rst_n)
    begin : track
        logic               want;
        logic [PAT_DEPTH:0] qrow;
        int                 k;
        if (!rst_n)
        begin
            for (k = 0; k < PAT_DEPTH; k++)
            begin
                pat_mem[k] = 8'h00;
            end
            row_bits = '0;
            len_reg = '0;
            expected_matches.delete();
            failures = 0;
            pending_results = 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_matches.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual matched=%0b",
                             $time, out_mon.matched);
                    failures++;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (out_mon.matched !== want)
                    begin
                        $display("%0t: matched mismatch, expected %0b, actual %0b",
                                 $time, want, out_mon.matched);
                        failures++;
                    end
                end
            end

            if (cfg_mon.valid && cfg_mon.ready)
            begin
                len_reg = cfg_mon.data;
            end

            if (in_mon.valid && in_mon.ready)
            begin
                case (in_mon.op)
                    wpm_pkg::OP_LOAD:
                    begin
                        if (in_mon.position < PAT_DEPTH)
                        begin
                            pat_mem[in_mon.position] = in_mon.byte_value;
                        end
                    end
                    wpm_pkg::OP_TEXT:
                    begin
                        if (in_mon.first_of_text)
                        begin
                            row_bits = empty_text_row();
                        end
                        row_bits = advance_row(row_bits, in_mon.byte_value);
                        if (in_mon.last_of_text)
                        begin
                            expected_matches.push_back(row_bits[used_len()]);
                        end
                    end
                    wpm_pkg::OP_QUERY:
                    begin
                        qrow = empty_text_row();
                        expected_matches.push_back(qrow[used_len()]);
                    end
                    default:
                    begin
                    end
                endcase
            end
            pending_results = expected_matches.size();
        end
    end

endmodule

@@ tb/wildcard_pattern_match_test.sv @@
`timescale 1ns / 100ps
// Top of the wildcard matcher testbench: clock, reset, request stimulus and verdict.
module wildcard_pattern_match_test;

    localparam int PAT_DEPTH     = 64;
    localparam int ITEM_TARGET   = 1050;
    localparam int SETTLE_CYCLES = 2 * (PAT_DEPTH + 2) + 8;
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 4000;
    localparam int LEN_FIELD_MAX = 127;

    logic clk;
    logic rst_n;
    int   failures;
    int   pending_results;
    int   items_sent;
    int   quiet_cycles;
    bit   in_idle;
    bit   out_idle;
    bit   hold_results;
    bit   row_fresh;
    bit   carry_open;
    int   cur_len;

    // Stimulus-side copy of the pattern, used to build texts that match.
    logic [7:0] pattern_img [PAT_DEPTH];
    bit         loaded [PAT_DEPTH];
    logic [7:0] text_bytes [$];

    wpm_in_if  in_ch();
    wpm_out_if out_ch();
    wpm_cfg_if cfg_ch();

    wildcard_pattern_match #(
        .MAX_PATTERN(PAT_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    wpm_match_check #(
        .PAT_DEPTH(PAT_DEPTH)
    ) u_match_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_mon          (in_ch),
        .out_mon         (out_ch),
        .cfg_mon         (cfg_ch),
        .failures        (failures),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Ends the run when no request, result or register write moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stalls per result, and one long hold-off on request.
    initial
    begin : result_sink
        int gap;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_results = 1'b0;
            end
            gap = out_idle ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (out_ch.valid !== 1'b1);
        end
    end

    // Offers one request after a random gap and returns at the edge that accepts it.
    task automatic send_request(input wpm_pkg::op_t op, input int pos, input logic [7:0] val,
                                input bit first, input bit last);
        int gap;
        gap = in_idle ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.op            <= op;
        in_ch.position      <= pos[5:0];
        in_ch.byte_value    <= val;
        in_ch.first_of_text <= first;
        in_ch.last_of_text  <= last;
        do
        begin
            @(posedge clk);
        end
        while (in_ch.ready !== 1'b1);
        if (op != wpm_pkg::OP_NONE)
        begin
            items_sent++;
        end
    endtask

    // Stops offering, waits for every expected result, then lets any sweep finish.
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (pending_results == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_length(input int len);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= len[6:0];
        do
        begin
            @(posedge clk);
        end
        while (cfg_ch.ready !== 1'b1);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cur_len = len;
    endtask

    task automatic load_byte(input int pos, input logic [7:0] val);
        send_request(wpm_pkg::OP_LOAD, pos, val, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        pattern_img[pos] = val;
        loaded[pos] = 1'b1;
    endtask

    function automatic int eff_len();
        return (cur_len > PAT_DEPTH) ? PAT_DEPTH : cur_len;
    endfunction

    function automatic bit prefix_ready(input int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            if (!loaded[k])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Text bytes lean on a small alphabet so that literals line up with the pattern.
    function automatic logic [7:0] random_text_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            return $urandom_range(0, 1) ? 8'h61 : 8'h62;
        end
        else if (r == 6)
        begin
            return wpm_pkg::STAR_BYTE;
        end
        else if (r == 7)
        begin
            return wpm_pkg::ANY_BYTE;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] random_pattern_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            return $urandom_range(0, 1) ? 8'h61 : 8'h62;
        end
        else if (r < 5)
        begin
            return wpm_pkg::STAR_BYTE;
        end
        else if (r < 7)
        begin
            return wpm_pkg::ANY_BYTE;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Builds a text that fits the current pattern, then optionally breaks it.
    task automatic build_text(input bit mutate);
        int         j;
        int         idx;
        logic [7:0] q;
        text_bytes.delete();
        for (j = 0; j < eff_len(); j++)
        begin
            q = pattern_img[j];
            if (q == wpm_pkg::STAR_BYTE)
            begin
                repeat ($urandom_range(0, 3)) text_bytes.push_back(random_text_byte());
            end
            else if (q == wpm_pkg::ANY_BYTE)
            begin
                text_bytes.push_back(random_text_byte());
            end
            else
            begin
                text_bytes.push_back(q);
            end
        end
        if (mutate && text_bytes.size() > 0)
        begin
            idx = $urandom_range(0, text_bytes.size() - 1);
            case ($urandom_range(0, 2))
                0: text_bytes[idx] = random_text_byte();
                1: text_bytes.delete(idx);
                default: text_bytes.push_back(random_text_byte());
            endcase
        end
    endtask

    task automatic send_text(input bit with_first, input bit close);
        int n;
        int i;
        n = text_bytes.size();
        for (i = 0; i < n; i++)
        begin
            send_request(wpm_pkg::OP_TEXT, $urandom_range(0, 63), text_bytes[i],
                         with_first && (i == 0), close && (i == n - 1));
        end
        if (with_first && n > 0)
        begin
            row_fresh = 1'b1;
        end
    endtask

    // Stimulus: directed cases, then phases of random pattern lengths and texts.
    initial
    begin : stimulus
        int  phase;
        int  new_len;
        int  p;
        int  t;
        int  r;
        int  text_count;
        bit  with_first;
        bit  close;
        bit  carry;

        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = wpm_pkg::OP_NONE;
        in_ch.position = '0;
        in_ch.byte_value = '0;
        in_ch.first_of_text = 1'b0;
        in_ch.last_of_text = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        hold_results = 1'b0;
        in_idle = 1'b1;
        out_idle = 1'b1;
        cur_len = 0;
        items_sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A text byte before any first flag runs on the all-zero row.
        send_request(wpm_pkg::OP_TEXT, 0, 8'h00, 1'b0, 1'b1);
        // Empty text and one-byte text against the empty pattern.
        send_request(wpm_pkg::OP_QUERY, 0, 8'h00, 1'b0, 1'b0);
        send_request(wpm_pkg::OP_TEXT, 0, 8'hFF, 1'b1, 1'b1);
        // The unused operation with every field bit set.
        send_request(wpm_pkg::OP_NONE, 63, 8'hFF, 1'b1, 1'b1);

        // Pattern: star, any, 0xFF, star, 0x00, plus the top store entry.
        load_byte(0, wpm_pkg::STAR_BYTE);
        load_byte(1, wpm_pkg::ANY_BYTE);
        load_byte(2, 8'hFF);
        load_byte(3, wpm_pkg::STAR_BYTE);
        load_byte(4, 8'h00);
        load_byte(63, 8'h5A);
        write_length(5);
        send_request(wpm_pkg::OP_QUERY, 63, 8'hFF, 1'b1, 1'b1);

        // Star bytes in the text meet star and any in the pattern.
        text_bytes = '{wpm_pkg::STAR_BYTE, wpm_pkg::STAR_BYTE, 8'hFF, 8'h00};
        send_text(1'b1, 1'b1);
        text_bytes = '{8'h41, 8'hFF, 8'h00};
        send_text(1'b1, 1'b1);

        // The pattern changes in the middle of a text.
        send_request(wpm_pkg::OP_TEXT, 0, 8'h41, 1'b1, 1'b0);
        load_byte(2, 8'h42);
        send_request(wpm_pkg::OP_TEXT, 0, 8'h42, 1'b0, 1'b0);
        send_request(wpm_pkg::OP_TEXT, 0, 8'h00, 1'b0, 1'b1);

        // The length changes in the middle of a text.
        send_request(wpm_pkg::OP_TEXT, 0, wpm_pkg::STAR_BYTE, 1'b1, 1'b0);
        write_length(2);
        send_request(wpm_pkg::OP_TEXT, 0, wpm_pkg::STAR_BYTE, 1'b0, 1'b1);

        phase = 0;
        carry_open = 1'b0;
        close = 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            in_idle = ($urandom_range(0, 3) != 0);
            out_idle = ($urandom_range(0, 3) != 0);

            // Pick the next length; random lengths past the store only once it is full.
            if (phase == 2)
            begin
                new_len = PAT_DEPTH;
            end
            else if (phase == 6)
            begin
                new_len = LEN_FIELD_MAX;
            end
            else if (prefix_ready(PAT_DEPTH) && $urandom_range(0, 9) == 0)
            begin
                new_len = $urandom_range(PAT_DEPTH, LEN_FIELD_MAX);
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                new_len = $urandom_range(7, 20);
            end
            else
            begin
                new_len = $urandom_range(0, 6);
            end
            carry = carry_open && prefix_ready(PAT_DEPTH);
            write_length(new_len);
            row_fresh = 1'b0;

            // Fresh pattern for short lengths or an unloaded prefix, eight touched bytes for long ones.
            if (eff_len() <= 20 || !prefix_ready(eff_len()))
            begin
                for (p = 0; p < eff_len(); p++)
                begin
                    load_byte(p, random_pattern_byte());
                end
            end
            else
            begin
                repeat (8) load_byte($urandom_range(0, eff_len() - 1), random_pattern_byte());
            end

            // Finish the text left open before the length was rewritten.
            if (carry)
            begin
                send_request(wpm_pkg::OP_TEXT, $urandom_range(0, 63), random_text_byte(),
                             1'b0, 1'b1);
            end
            carry_open = 1'b0;

            // Long result hold-off while queries keep coming, so the input stalls.
            if (phase == 4)
            begin
                hold_results = 1'b1;
                repeat (12)
                begin
                    send_request(wpm_pkg::OP_QUERY, $urandom_range(0, 63),
                                 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end

            text_count = (eff_len() > 20) ? 2 : $urandom_range(4, 10);
            for (t = 0; t < text_count; t++)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                begin
                    send_request(wpm_pkg::OP_NONE, $urandom_range(0, 63),
                                 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                else if (r == 1)
                begin
                    load_byte($urandom_range(0, 63), random_pattern_byte());
                end
                else if (r == 2)
                begin
                    send_request(wpm_pkg::OP_QUERY, $urandom_range(0, 63),
                                 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    if (r == 3)
                    begin
                        text_bytes.delete();
                        repeat ($urandom_range(1, 8)) text_bytes.push_back(random_text_byte());
                    end
                    else
                    begin
                        build_text(r < 8);
                    end
                    // Now and then a text continues the previous row or is dropped unfinished.
                    with_first = !(row_fresh && $urandom_range(0, 15) == 0);
                    close = ($urandom_range(0, 15) != 0);
                    if (text_bytes.size() == 0)
                    begin
                        send_request(wpm_pkg::OP_QUERY, $urandom_range(0, 63),
                                     8'($urandom_range(0, 255)),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    end
                    else
                    begin
                        send_text(with_first, close);
                    end
                end
            end

            // Leave a text open across the next length write.
            if ($urandom_range(0, 3) == 0)
            begin
                build_text(1'b0);
                text_bytes.push_back(random_text_byte());
                send_text(1'b1, 1'b0);
                carry_open = 1'b1;
            end
            phase++;
        end

        wait_idle();
        if (failures == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/wpm_pkg.sv
rtl/wpm_if.sv
rtl/wpm_cell.sv
rtl/wildcard_pattern_match.sv
tb/wpm_match_check.sv
tb/wildcard_pattern_match_test.sv
